// ===== src/bdh_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package bdh_pkg;

	// Field widths of one sample and one event
	localparam int IDX_W    = 3;
	localparam int TIME_W   = 32;
	localparam int CFG_W    = 16;
	localparam int CFG_IDX_W = 1;

	localparam int BUTTONS_DEFAULT = 8;
	localparam int INDEX_SPAN      = 2 ** IDX_W;

	localparam logic [CFG_W-1:0] DEBOUNCE_RESET = 16'd50;
	localparam logic [CFG_W-1:0] HOLD_RESET     = 16'd800;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HOLD     = 1'd1;

	typedef enum logic [1:0] {
		EV_NONE     = 2'd0,
		EV_PRESSED  = 2'd1,
		EV_RELEASED = 2'd2,
		EV_HELD     = 2'd3
	} event_t;

	typedef struct packed {
		logic [IDX_W-1:0]  button;
		logic              level;
		logic [TIME_W-1:0] stamp;
	} sample_t;

endpackage

`default_nettype wire

// ===== src/bdh_button_state.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bdh_button_state #(
	parameter int BUTTONS = bdh_pkg::BUTTONS_DEFAULT
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          upd,
	input  wire bdh_pkg::sample_t              sample,
	input  wire logic [bdh_pkg::CFG_W-1:0]     debounce_ms,
	input  wire logic [bdh_pkg::CFG_W-1:0]     hold_ms,
	output bdh_pkg::event_t                    code
);

	// Only as many entries as the index field can reach
	localparam int DEPTH = (BUTTONS < bdh_pkg::INDEX_SPAN) ? BUTTONS : bdh_pkg::INDEX_SPAN;
	localparam int SEL_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic                        stable_q   [DEPTH];
	logic [bdh_pkg::TIME_W-1:0]  edge_t_q   [DEPTH];
	logic [bdh_pkg::TIME_W-1:0]  start_t_q  [DEPTH];
	logic                        timing_q   [DEPTH];
	logic                        reported_q [DEPTH];

	logic                        in_range;
	logic [SEL_W-1:0]            sel;
	logic [bdh_pkg::TIME_W-1:0]  since_edge;
	logic [bdh_pkg::TIME_W-1:0]  since_press;
	logic                        change;
	logic                        accept_chg;
	logic                        held;

	assign in_range = 32'(sample.button) < BUTTONS;
	assign sel      = in_range ? sample.button[SEL_W-1:0] : '0;

	// Differences wrap modulo 2^32
	assign since_edge  = sample.stamp - edge_t_q[sel];
	assign since_press = sample.stamp - start_t_q[sel];

	assign change     = in_range && (sample.level != stable_q[sel]);
	assign accept_chg = change &&
		(since_edge >= {{(bdh_pkg::TIME_W-bdh_pkg::CFG_W){1'b0}}, debounce_ms});
	assign held = in_range && !change && !stable_q[sel] && timing_q[sel] &&
		!reported_q[sel] &&
		(since_press >= {{(bdh_pkg::TIME_W-bdh_pkg::CFG_W){1'b0}}, hold_ms});

	always_comb begin
		code = bdh_pkg::EV_NONE;
		if (accept_chg) begin
			code = sample.level ? bdh_pkg::EV_RELEASED : bdh_pkg::EV_PRESSED;
		end else if (held) begin
			code = bdh_pkg::EV_HELD;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DEPTH; i++) begin
				stable_q[i]   <= 1'b1;
				edge_t_q[i]   <= '0;
				start_t_q[i]  <= '0;
				timing_q[i]   <= 1'b0;
				reported_q[i] <= 1'b0;
			end
		end else if (upd) begin
			if (accept_chg) begin
				stable_q[sel]   <= sample.level;
				edge_t_q[sel]   <= sample.stamp;
				reported_q[sel] <= 1'b0;
				// press starts hold timing, release drops it
				start_t_q[sel]  <= sample.level ? '0 : sample.stamp;
				timing_q[sel]   <= !sample.level;
			end else if (held) begin
				reported_q[sel] <= 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ===== src/button_debounce_hold_detector_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Debounces up to eight buttons and reports pressed, released and held events.
// Each word in is one pin sample (button, active-low level, ms timestamp); each
// word out is one event for that sample, code none included. One sample is
// taken every cycle unless in_stall is high; the sample register feeds the
// combinational per-button state compare/update, and the event register holds
// the result while the sink stalls. The user writes debounce_ms and hold_ms
// through cfg_we/cfg_index/cfg_wdata only while no samples are in flight; the
// block does not enforce this. Indexes at or above BUTTONS pass as code none.
module button_debounce_hold_detector_unit #(
	parameter int BUTTONS = bdh_pkg::BUTTONS_DEFAULT
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,

	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire logic [bdh_pkg::IDX_W-1:0]         button_index,
	input  wire logic                              pin_level,
	input  wire logic [bdh_pkg::TIME_W-1:0]        time_ms,

	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic [1:0]                             event_code,
	output logic [bdh_pkg::IDX_W-1:0]              event_button,

	input  wire logic                              cfg_we,
	input  wire logic [bdh_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [bdh_pkg::CFG_W-1:0]         cfg_wdata
);

	logic [bdh_pkg::CFG_W-1:0]    debounce_q;
	logic [bdh_pkg::CFG_W-1:0]    hold_q;

	logic                         valid_s1;
	bdh_pkg::sample_t             sample_s1;

	logic                         out_valid_q;
	bdh_pkg::event_t              code_q;
	logic [bdh_pkg::IDX_W-1:0]    button_q;

	logic                         advance;
	bdh_pkg::event_t              code;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q <= bdh_pkg::DEBOUNCE_RESET;
			hold_q     <= bdh_pkg::HOLD_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				bdh_pkg::CFG_DEBOUNCE: debounce_q <= cfg_wdata;
				bdh_pkg::CFG_HOLD:     hold_q     <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Advance the sample into the event register when that register frees up
	assign advance  = !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			sample_s1 <= '{button: button_index, level: pin_level, stamp: time_ms};
		end
	end

	bdh_button_state #(
		.BUTTONS (BUTTONS)
	) u_state (
		.clk         (clk),
		.arst_n      (arst_n),
		.upd         (valid_s1 && advance),
		.sample      (sample_s1),
		.debounce_ms (debounce_q),
		.hold_ms     (hold_q),
		.code        (code)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			code_q   <= code;
			button_q <= sample_s1.button;
		end
	end

	assign out_valid    = out_valid_q;
	assign event_code   = code_q;
	assign event_button = button_q;

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid_q && out_stall))
		else $error("input stalled while event register can drain");

	a_sample_reaches_output: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && advance) |=> out_valid_q)
		else $error("sample dropped between stages");

	a_event_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (code_q != bdh_pkg::EV_NONE)) |-> (32'(button_q) < BUTTONS))
		else $error("event reported for a button beyond range");

endmodule

`default_nettype wire
